[hdl/lr_pkg.sv]
// shared types and constants for the line rasterizer
package lr_pkg;

    localparam int COORD_W = 6;
    localparam int ERR_W   = COORD_W + 2;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } line_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } pixel_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        coord_t abs_dx;
        coord_t abs_dy;
        logic   step_x_neg;
        logic   step_y_neg;
    } cmd_t;

endpackage

[hdl/lr_front.sv]
// command setup: step directions and absolute distances of a line
module lr_front
(
    input  lr_pkg::line_t line,
    output lr_pkg::cmd_t  cmd
);
    import lr_pkg::*;

    logic x_neg;
    logic y_neg;

    assign x_neg = !(line.start_x < line.end_x);
    assign y_neg = !(line.start_y < line.end_y);

    always_comb
    begin
        cmd.start_x    = line.start_x;
        cmd.start_y    = line.start_y;
        cmd.end_x      = line.end_x;
        cmd.end_y      = line.end_y;
        cmd.step_x_neg = x_neg;
        cmd.step_y_neg = y_neg;
        cmd.abs_dx     = x_neg ? (line.start_x - line.end_x) : (line.end_x - line.start_x);
        cmd.abs_dy     = y_neg ? (line.start_y - line.end_y) : (line.end_y - line.start_y);
    end

endmodule

[hdl/lr_cmd_queue.sv]
// two-entry command queue between setup and walker
module lr_cmd_queue
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  lr_pkg::cmd_t wr_data,
    output logic         full,
    input  logic         rd,
    output logic         rd_valid,
    output lr_pkg::cmd_t rd_data
);
    import lr_pkg::*;

    cmd_t slot0_reg;
    cmd_t slot1_reg;
    logic v0_reg;
    logic v1_reg;
    logic push_ok;
    logic pop_ok;

    assign full     = v1_reg;
    assign rd_valid = v0_reg;
    assign rd_data  = slot0_reg;
    assign push_ok  = wr && !v1_reg;
    assign pop_ok   = rd && v0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (pop_ok)
        begin
            v0_reg <= v1_reg || push_ok;
            v1_reg <= 1'b0;
        end
        else if (push_ok)
        begin
            if (!v0_reg)
                v0_reg <= 1'b1;
            else
                v1_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ok)
        begin
            if (v1_reg)
                slot0_reg <= slot1_reg;
            else if (push_ok)
                slot0_reg <= wr_data;
        end
        else if (push_ok)
        begin
            if (!v0_reg)
                slot0_reg <= wr_data;
            else
                slot1_reg <= wr_data;
        end
    end

    a_order: assert property (@(posedge clk) disable iff (!rst_n) v1_reg |-> v0_reg)
        else $error("queue tail valid without head");
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !pop_ok) |=> v1_reg)
        else $error("queue entry dropped without pop");

endmodule

[hdl/lr_walker.sv]
// bresenham walker with registered pixel output
module lr_walker
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  lr_pkg::cmd_t  cmd,
    output logic          cmd_take,
    output lr_pkg::pixel_t pixel,
    output logic          out_valid,
    input  logic          out_take
);
    import lr_pkg::*;

    logic                    busy_reg;
    coord_t                  cur_x_reg;
    coord_t                  cur_y_reg;
    coord_t                  end_x_reg;
    coord_t                  end_y_reg;
    coord_t                  abs_dx_reg;
    coord_t                  abs_dy_reg;
    logic                    step_x_neg_reg;
    logic                    step_y_neg_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] err_next;
    logic signed [ERR_W-1:0] err_init;
    logic signed [ERR_W:0]   e2;
    logic signed [ERR_W:0]   neg_dy;
    logic signed [ERR_W:0]   pos_dx;
    logic                    step_x;
    logic                    step_y;
    logic                    done;
    logic                    emit;
    pixel_t                  pixel_reg;
    logic                    out_valid_reg;

    assign cmd_take  = !busy_reg;
    assign pixel     = pixel_reg;
    assign out_valid = out_valid_reg;

    assign done   = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
    assign emit   = busy_reg && (!out_valid_reg || out_take);
    assign e2     = {err_reg, 1'b0};
    assign pos_dx = $signed({3'b000, abs_dx_reg});
    assign neg_dy = -$signed({3'b000, abs_dy_reg});
    assign step_x = e2 > neg_dy;
    assign step_y = e2 < pos_dx;

    always_comb
    begin
        err_next = err_reg;
        if (step_x)
            err_next = err_next - $signed({2'b00, abs_dy_reg});
        if (step_y)
            err_next = err_next + $signed({2'b00, abs_dx_reg});
    end

    assign err_init = $signed({2'b00, cmd.abs_dx}) - $signed({2'b00, cmd.abs_dy});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!busy_reg)
                busy_reg <= cmd_valid;
            else if (emit && done)
                busy_reg <= 1'b0;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && cmd_valid)
        begin
            cur_x_reg      <= cmd.start_x;
            cur_y_reg      <= cmd.start_y;
            end_x_reg      <= cmd.end_x;
            end_y_reg      <= cmd.end_y;
            abs_dx_reg     <= cmd.abs_dx;
            abs_dy_reg     <= cmd.abs_dy;
            step_x_neg_reg <= cmd.step_x_neg;
            step_y_neg_reg <= cmd.step_y_neg;
            err_reg        <= err_init;
        end
        else if (emit && !done)
        begin
            err_reg <= err_next;
            if (step_x)
                cur_x_reg <= step_x_neg_reg ? cur_x_reg - coord_t'(1) : cur_x_reg + coord_t'(1);
            if (step_y)
                cur_y_reg <= step_y_neg_reg ? cur_y_reg - coord_t'(1) : cur_y_reg + coord_t'(1);
        end

        if (emit)
        begin
            pixel_reg.pixel_x    <= cur_x_reg;
            pixel_reg.pixel_y    <= cur_y_reg;
            pixel_reg.last_pixel <= done;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_take) |=> (out_valid_reg && $stable(pixel_reg)))
        else $error("waiting pixel changed before pop");
    a_end_line: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && done) |=> (!busy_reg && out_valid_reg && pixel_reg.last_pixel))
        else $error("last pixel did not close the line");

endmodule

[hdl/line_rasterizer.sv]
// line rasterizer top level: setup, command queue and pixel walker
// A line command is taken when push is high and full is low; up to three
// commands can be held (one in the walker, two queued). Each line yields
// max(|dx|,|dy|)+1 pixel transactions, first endpoint first and second
// endpoint last with last_pixel set. The walker first loads a command and
// then emits one pixel per cycle while pop keeps up; lines are walked one
// at a time by the single walker.
module line_rasterizer
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  lr_pkg::line_t  line,
    output logic           empty,
    input  logic           pop,
    output lr_pkg::pixel_t pixel
);
    import lr_pkg::*;

    cmd_t setup_cmd;
    cmd_t queue_cmd;
    logic queue_valid;
    logic walker_take;
    logic out_valid;

    lr_front u_front
    (
        .line (line),
        .cmd  (setup_cmd)
    );

    lr_cmd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (push),
        .wr_data  (setup_cmd),
        .full     (full),
        .rd       (walker_take),
        .rd_valid (queue_valid),
        .rd_data  (queue_cmd)
    );

    lr_walker u_walker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .cmd_take  (walker_take),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_take  (pop)
    );

    assign empty = !out_valid;

endmodule
